@@ rtl/sacl_pkg.sv @@
package sacl_pkg;

    localparam int SETS   = 256;
    localparam int WAYS   = 8;
    localparam int ADDR_W = 31;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DIV_W  = SET_W + 1;
    localparam int NWAY_W = WAY_W + 1;
    localparam int CNT_W  = $clog2(ADDR_W + 1);

    // Configuration port.
    localparam int SCFG_W     = 9;
    localparam int WCFG_W     = 4;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 1'd1;
    localparam logic [SCFG_W-1:0] SETS_RESET = 9'd256;
    localparam logic [WCFG_W-1:0] WAYS_RESET = 4'd8;

    // Stream widths.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // Result kinds.
    localparam logic [1:0] KIND_HIT   = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_EVICT = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // One memory row holds a whole set.
    typedef struct packed {
        logic [WAYS-1:0]              vld;
        logic [WAY_W-1:0]             vp;
        logic [WAYS-1:0][ADDR_W-1:0]  tag;
    } t_row;

    typedef struct packed {
        logic start;   // latch the item and start the remainder
        logic rd;      // read the set row
        logic commit;  // write the row back and load the result register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_stat;

endpackage

@@ rtl/sacl_rem.sv @@
module sacl_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sacl_pkg::ADDR_W-1:0]  i_dividend,
    input  logic [sacl_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [sacl_pkg::SET_W-1:0]   o_rem
);
    import sacl_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_sh;
    logic [SET_W-1:0]  r_rem;
    logic [DIV_W-1:0]  trial;
    logic [DIV_W-1:0]  diff;

    // Restoring remainder, one dividend bit per cycle, most significant first.
    always_comb begin
        trial = {r_rem, r_sh[ADDR_W-1]};
        diff  = (trial >= i_divisor) ? (trial - i_divisor) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ADDR_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_sh  <= {r_sh[ADDR_W-2:0], 1'b0};
            r_rem <= diff[SET_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

@@ rtl/sacl_dp.sv @@
module sacl_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sacl_pkg::t_cmd                   i_cmd,
    output sacl_pkg::t_stat                  o_stat,
    input  logic [sacl_pkg::ADDR_W-1:0]      i_addr,
    input  logic                             i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_hit,
    output logic [1:0]                       o_kind,
    output logic [sacl_pkg::WAY_W-1:0]       o_way
);
    import sacl_pkg::*;

    logic [SCFG_W-1:0] r_sets_cfg;
    logic [WCFG_W-1:0] r_ways_cfg;
    logic [DIV_W-1:0]  nsets;
    logic [NWAY_W-1:0] nways;

    logic [ADDR_W-1:0] r_addr;
    logic              div_busy;
    logic [SET_W-1:0]  set_idx;

    t_row              mem [SETS];
    logic [SETS-1:0]   r_row_vld;
    t_row              r_q;
    logic              r_qv;
    t_row              row;
    t_row              new_row;

    logic [WAYS-1:0]   in_use;
    logic [WAYS-1:0]   hitv;
    logic [WAYS-1:0]   emptyv;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  empty_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  vnext;
    logic              res_hit;
    logic [1:0]        res_kind;
    logic [WAY_W-1:0]  res_way;

    logic [WAY_W-1:0]  r_out_way;
    logic [1:0]        r_out_kind;
    logic              r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets_cfg <= SETS_RESET;
            r_ways_cfg <= WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETS: r_sets_cfg <= i_cfg_data[SCFG_W-1:0];
                CFG_WAYS: r_ways_cfg <= i_cfg_data[WCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts act as one; counts above the built size saturate.
    always_comb begin
        if (r_sets_cfg == '0) begin
            nsets = DIV_W'(1);
        end else if (r_sets_cfg > SCFG_W'(SETS)) begin
            nsets = DIV_W'(SETS);
        end else begin
            nsets = DIV_W'(r_sets_cfg);
        end
        if (r_ways_cfg == '0) begin
            nways = NWAY_W'(1);
        end else if (r_ways_cfg > WCFG_W'(WAYS)) begin
            nways = NWAY_W'(WAYS);
        end else begin
            nways = NWAY_W'(r_ways_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= i_addr;
        end
    end

    sacl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (i_addr),
        .i_divisor  (nsets),
        .o_busy     (div_busy),
        .o_rem      (set_idx)
    );

    assign o_stat.div_busy = div_busy;

    // Set rows: a row never written since reset reads as all empty.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_q <= mem[set_idx];
        end
        if (i_cmd.commit) begin
            mem[set_idx] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_qv      <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_qv <= r_row_vld[set_idx];
            end
            if (i_cmd.commit) begin
                r_row_vld[set_idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        row = r_qv ? r_q : '0;
        for (int w = 0; w < WAYS; w++) begin
            in_use[w] = (NWAY_W'(w) < nways);
            hitv[w]   = row.vld[w] && in_use[w] && (row.tag[w] == r_addr);
            emptyv[w] = !row.vld[w] && in_use[w];
        end
        hit_way   = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) begin
                hit_way = WAY_W'(w);
            end
            if (emptyv[w]) begin
                empty_way = WAY_W'(w);
            end
        end
        victim = ({1'b0, row.vp} >= nways) ? '0 : row.vp;
        vnext  = ({1'b0, victim} + 1'b1 == nways) ? '0 : victim + 1'b1;

        new_row = row;
        if (hitv != '0) begin
            res_hit  = 1'b1;
            res_kind = KIND_HIT;
            res_way  = hit_way;
        end else if (emptyv != '0) begin
            res_hit                = 1'b0;
            res_kind               = KIND_FILL;
            res_way                = empty_way;
            new_row.vld[empty_way] = 1'b1;
            new_row.tag[empty_way] = r_addr;
        end else begin
            res_hit             = 1'b0;
            res_kind            = KIND_EVICT;
            res_way             = victim;
            new_row.tag[victim] = r_addr;
            new_row.vp          = vnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit  <= res_hit;
            r_out_kind <= res_kind;
            r_out_way  <= res_way;
        end
    end

    assign o_hit  = r_out_hit;
    assign o_kind = r_out_kind;
    assign o_way  = r_out_way;

endmodule

@@ rtl/sacl_ctrl.sv @@
module sacl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sacl_pkg::t_cmd   o_cmd,
    input  sacl_pkg::t_stat  i_stat
);
    import sacl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        o_cmd.start  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rd     = (r_state == ST_DIV) && !i_stat.div_busy;
        o_cmd.commit = (r_state == ST_RES) && (!r_ovalid || i_out_ready);
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (o_cmd.rd) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (o_cmd.commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.commit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

@@ rtl/set_assoc_fifo_cache_lookup_unit.sv @@
// Channel   Direction  Ports                      Contents
// s_axis    in         i_s_axis_t{valid,data}     one address per item
//                      o_s_axis_tready
// m_axis    out        o_m_axis_t{valid,data}     one lookup result per item
//                      i_m_axis_tready
// cfg       in         i_cfg_{we,idx,data}        set count (0), way count (1)
//
// Each item goes from acceptance to the result register through the bit-serial
// remainder unit that picks the set, a read of the set row from memory, and a
// compare of all ways that writes the row back. The input reopens on the cycle
// after that, so a new item is taken only once the last one has been committed.
// Reset is synchronous and active low; it clears the control state, the per-set
// row valid flags and the configuration registers, so no clearing pass is needed.
// A new item is taken while an earlier result still waits on m_axis; a stall
// there holds the finished item in the compare stage until the register frees.
module set_assoc_fifo_cache_lookup_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item in: [30:0] address, [31] zero.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sacl_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // Item out: [0] hit, [2:1] miss_kind, [5:3] way_used, [7:6] zero.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sacl_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sacl_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic              res_hit;
    logic [1:0]        res_kind;
    logic [WAY_W-1:0]  res_way;

    // The controller sequences each item through remainder, row read and
    // resolve; it also owns the output valid flag.
    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // The datapath holds the configuration, the set memory and the result.
    sacl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_addr     (i_s_axis_tdata[ADDR_W-1:0]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_hit      (res_hit),
        .o_kind     (res_kind),
        .o_way      (res_way)
    );

    assign o_m_axis_tdata = M_DATA_W'({res_way, res_kind, res_hit});

    // The input is only open while no remainder is in progress.
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !stat.div_busy)
        else $error("input ready while the remainder unit is busy");

    // A committed result is presented on the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_m_axis_tvalid)
        else $error("committed result not presented");

    // The hit flag agrees with the result kind.
    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res_hit == (res_kind == KIND_HIT)) && (res_kind != KIND_NONE))
        else $error("hit flag and result kind disagree");

    // The set row is read only once the remainder is finished.
    a_read_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |-> !stat.div_busy && !cmd.start)
        else $error("set row read before the remainder is done");

endmodule

@@ tb/sacl_lookup_checker.sv @@
`timescale 1ns / 1ps

// Watches the address, result and configuration channels of the lookup unit.
// It keeps its own copy of the cache state and checks every result in order.
module sacl_lookup_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [sacl_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [sacl_pkg::M_DATA_W-1:0]   i_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_outstanding,
    output int                              o_mismatches
);
    import sacl_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [1:0]       kind;
        logic [WAY_W-1:0] way;
    } t_lookup_result;

    logic              line_valid [SETS*WAYS];
    logic [ADDR_W-1:0] line_tag   [SETS*WAYS];
    logic [WAY_W-1:0]  victim_ptr [SETS];
    logic [SCFG_W-1:0] sets_cfg;
    logic [WCFG_W-1:0] ways_cfg;

    t_lookup_result expected_results [$];
    int             mismatch_total = 0;
    int             results_seen   = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string what);
        if (mismatch_total < 100)
            $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, what);
        mismatch_total++;
    endtask

    // Looks the address up in the shadow cache, applies the fill or replacement
    // and returns the result the unit must produce.
    function automatic t_lookup_result predict_lookup(input logic [ADDR_W-1:0] addr);
        int unsigned    nsets;
        int unsigned    nways;
        int unsigned    set_idx;
        int unsigned    base;
        int unsigned    victim;
        int unsigned    w;
        t_lookup_result res;
        nsets   = (sets_cfg == 0) ? 1 : ((sets_cfg > SETS) ? SETS : sets_cfg);
        nways   = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
        set_idx = addr % nsets;
        base    = set_idx * WAYS;
        for (w = 0; w < nways; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == addr) begin
                res = '{hit: 1'b1, kind: KIND_HIT, way: w[WAY_W-1:0]};
                return res;
            end
        end
        for (w = 0; w < nways; w++) begin
            if (!line_valid[base+w]) begin
                line_valid[base+w] = 1'b1;
                line_tag[base+w]   = addr;
                res = '{hit: 1'b0, kind: KIND_FILL, way: w[WAY_W-1:0]};
                return res;
            end
        end
        // Set is full. A pointer left past the way count restarts at way 0.
        victim = victim_ptr[set_idx];
        if (victim >= nways)
            victim = 0;
        line_tag[base+victim] = addr;
        victim_ptr[set_idx]   = (victim + 1) % nways;
        res = '{hit: 1'b0, kind: KIND_EVICT, way: victim[WAY_W-1:0]};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result got;
        t_lookup_result want;
        t_lookup_result pred;
        if (!i_rst_n) begin
            for (int i = 0; i < SETS*WAYS; i++)
                line_valid[i] = 1'b0;
            for (int i = 0; i < SETS; i++)
                victim_ptr[i] = '0;
            sets_cfg = SETS_RESET;
            ways_cfg = WAYS_RESET;
            expected_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.hit  = i_m_axis_tdata[0];
                got.kind = i_m_axis_tdata[2:1];
                got.way  = i_m_axis_tdata[3 +: WAY_W];
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with no lookup outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit got %0b expected %0b",
                                                  got.hit, want.hit));
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("miss_kind got %0d expected %0d",
                                                  got.kind, want.kind));
                    if (got.way !== want.way)
                        report_mismatch($sformatf("way_used got %0d expected %0d",
                                                  got.way, want.way));
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SETS)
                    sets_cfg = i_cfg_data[SCFG_W-1:0];
                else if (i_cfg_idx == CFG_WAYS)
                    ways_cfg = i_cfg_data[WCFG_W-1:0];
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pred             = predict_lookup(i_s_axis_tdata[ADDR_W-1:0]);
                expected_results = {expected_results, pred};
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

@@ tb/tb_set_assoc_fifo_cache_lookup_unit.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the set-associative lookup unit. The checker beside
// the unit does all prediction and comparison; this module only drives the clock,
// the reset, the address stream, the result ready and the configuration port.
module tb_set_assoc_fifo_cache_lookup_unit;
    import sacl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 173;
    localparam int HOT_ENTRIES  = 24;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata    = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_SETS;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int outstanding;
    int mismatches;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Active set count of the current phase, used only to aim addresses at a
    // few sets so that hits and replacements happen often.
    int unsigned       stim_sets = SETS;
    logic [ADDR_W-1:0] hot_addr [HOT_ENTRIES];

    set_assoc_fifo_cache_lookup_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    sacl_lookup_checker lookup_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_outstanding   (outstanding),
        .o_mismatches    (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The result side stalls at random, one decision per cycle, at the rate
    // the current phase asks for.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Presents one address and returns at the edge where it is taken. Valid is
    // left high afterwards, so back-to-back items never lower and raise it in
    // the same step; a gap or the drain lowers it instead.
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-ADDR_W){1'b0}}, addr};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stops the stream and waits until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Both registers are written back to back while the unit is idle.
    task automatic write_config(input logic [SCFG_W-1:0] sets, input logic [WCFG_W-1:0] ways);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SETS;
        cfg_data <= sets;
        @(posedge i_clk);
        cfg_idx  <= CFG_WAYS;
        cfg_data <= {{(CFG_DATA_W-WCFG_W){1'b0}}, ways};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        stim_sets = (sets == 0) ? 1 : ((sets > SETS) ? SETS : sets);
    endtask

    // An address in one of the first sets (up to four), with a random tag part
    // bounded by tag_max and by the address range.
    function automatic logic [ADDR_W-1:0] aimed_address(input int unsigned tag_max);
        int unsigned set_idx;
        int unsigned k_max;
        set_idx = $urandom_range((stim_sets < 4) ? stim_sets - 1 : 3, 0);
        k_max   = (32'h7FFF_FFFF - set_idx) / stim_sets;
        if (tag_max < k_max)
            k_max = tag_max;
        return ADDR_W'(set_idx + stim_sets * $urandom_range(k_max, 0));
    endfunction

    // Most items reuse a small pool of addresses crowded into a few sets, which
    // drives the sets through filling, hitting and round-robin replacement.
    // The rest are near neighbors in the same sets and plain random addresses.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return hot_addr[$urandom_range(HOT_ENTRIES-1)];
        else if (roll < 85)
            return aimed_address(15);
        else
            return ADDR_W'($urandom);
    endfunction

    initial begin
        logic [SCFG_W-1:0] phase_sets;
        logic [WCFG_W-1:0] phase_ways;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration of 256 sets by 8 ways. Address
        // zero must miss into an empty way first and only then hit.
        send_address('0);
        send_address('0);
        send_address({ADDR_W{1'b1}});
        // Fill set 0 to the top, then replace in first-in order.
        for (int i = 1; i < 8; i++)
            send_address(ADDR_W'(i * 256));
        send_address(ADDR_W'(2048));
        send_address(ADDR_W'(2048));
        send_address('0);
        send_address({ADDR_W{1'b1}});

        // Lowering the way count leaves the victim pointer of set 0 past the
        // end, so way 0 is the one replaced.
        write_config(9'd256, 4'd2);
        send_address(ADDR_W'(4096));
        send_address(ADDR_W'(32'h2AAA_AAAA));
        send_address(ADDR_W'(32'h5555_5555));

        // Zero sets and zero ways act as one of each.
        write_config(9'd0, 4'd0);
        send_address(ADDR_W'(5));
        send_address(ADDR_W'(5));
        send_address(ADDR_W'(6));

        // Counts above the sizes saturate. Lines kept in ways that were out of
        // use become visible again.
        write_config(9'd511, 4'd15);
        send_address({ADDR_W{1'b1}});
        send_address(ADDR_W'(1024));

        // A line stored under 256 sets that lands in the same set under 3.
        write_config(9'd3, 4'd8);
        send_address(ADDR_W'(768));

        // Random phases, each with its own configuration and idling pattern.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin phase_sets = 9'd256; phase_ways = 4'd8;  end
                1: begin phase_sets = 9'd1;   phase_ways = 4'd1;  end
                2: begin phase_sets = 9'd3;   phase_ways = 4'd8;  end
                3: begin phase_sets = 9'd511; phase_ways = 4'd15; end
                4: begin phase_sets = 9'd7;   phase_ways = 4'd3;  end
                5: begin phase_sets = 9'd255; phase_ways = 4'd5;  end
                6: begin phase_sets = 9'd0;   phase_ways = 4'd0;  end
                7: begin phase_sets = 9'd2;   phase_ways = 4'd8;  end
                default: begin
                    phase_sets = SCFG_W'($urandom_range(511));
                    phase_ways = WCFG_W'($urandom_range(15));
                end
            endcase
            write_config(phase_sets, phase_ways);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase

            for (int i = 0; i < HOT_ENTRIES; i++)
                hot_addr[i] = aimed_address(32'h7FFF_FFFF);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_address(pick_address());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
